// File: hdl/pwg_pkg.sv
// ----------------------------------------------------------------------------
// pwg_pkg
// Shared types and constants of the periodic waveform generator.
// ----------------------------------------------------------------------------
package pwg_pkg;

  typedef enum logic [1:0] {
    MODE_SINE     = 2'd0,
    MODE_SQUARE   = 2'd1,
    MODE_TRIANGLE = 2'd2,
    MODE_SAWTOOTH = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_MODE        = 3'd0,
    REG_SINE_FREQ   = 3'd1,
    REG_WAVE_PERIOD = 3'd2,
    REG_AMPLITUDE   = 3'd3,
    REG_TIME_OFFSET = 3'd4,
    REG_TURN_OFFSET = 3'd5
  } reg_idx_e;

  typedef struct packed {
    mode_e              mode;
    logic [31:0]        sine_frequency;
    logic [31:0]        wave_period;
    logic signed [15:0] amplitude;
    logic [31:0]        time_offset;
    logic [15:0]        turn_offset;
  } cfg_t;

  typedef struct packed {
    logic [31:0] sample_time;
    logic        is_sine;
  } item_t;

  typedef struct packed {
    logic signed [15:0] level;
    logic               period_fault;
  } res_t;

  localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
  localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
  localparam logic [15:0] LEVEL_MAX  = 16'd32767;

  localparam int unsigned SIN_STEPS = 6;
  localparam int unsigned SIN_DIV [SIN_STEPS] = '{156, 110, 72, 42, 20, 6};

  // saturate a magnitude and apply its sign
  function automatic logic signed [15:0] sat_level(input logic [15:0] mag, input logic neg);
    logic [15:0] m;
    m = (mag > LEVEL_MAX) ? LEVEL_MAX : mag;
    return neg ? -$signed(m) : $signed(m);
  endfunction

endpackage

// File: hdl/pwg_front.sv
// ----------------------------------------------------------------------------
// pwg_front
// Input register: takes a sample beat and tags it for the sine or wave unit.
// ----------------------------------------------------------------------------
module pwg_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [31:0]    in_time_i,
  input  pwg_pkg::mode_e mode_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pwg_pkg::item_t out_item_o
);
  import pwg_pkg::*;

  logic  valid_q;
  item_t item_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q.sample_time <= in_time_i;
      item_q.is_sine     <= (mode_i == MODE_SINE);
    end
  end

endmodule

// File: hdl/pwg_queue.sv
// ----------------------------------------------------------------------------
// pwg_queue
// Short fifo between the front register and the execution units.
// ----------------------------------------------------------------------------
module pwg_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  pwg_pkg::item_t push_item_i,
  output logic           pop_valid_o,
  input  logic           pop_i,
  output pwg_pkg::item_t pop_item_o
);
  import pwg_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t             mem_q [DEPTH];
  logic [AW-1:0]     wptr_q, rptr_q;
  logic [AW:0]       count_q;
  logic              push, pop;

  assign push_ready_o = (count_q != (AW+1)'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_item_o   = mem_q[rptr_q];

  function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push) wptr_q <= next_ptr(wptr_q);
      if (pop)  rptr_q <= next_ptr(rptr_q);
      if (push && !pop) count_q <= count_q + (AW+1)'(1);
      else if (pop && !push) count_q <= count_q - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= push_item_i;
  end

endmodule

// File: hdl/pwg_sine.sv
// ----------------------------------------------------------------------------
// pwg_sine
// Sine pipeline: phase product, quadrant fold, odd polynomial, scaling.
// ----------------------------------------------------------------------------
module pwg_sine #(
  parameter int unsigned PHASE_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [31:0]   time_i,
  input  pwg_pkg::cfg_t cfg_i,
  output logic          valid_o,
  output pwg_pkg::res_t res_o
);
  import pwg_pkg::*;

  localparam int unsigned UW = PHASE_BITS - 1;
  localparam logic [UW-1:0] QSIZE = UW'(1) << (PHASE_BITS - 2);

  typedef struct packed {
    logic [30:0] x;
    logic [31:0] x2;
    logic [1:0]  quad;
  } sin_ctx_t;

  // phase
  logic [31:0] prod_lo, phase_q;
  logic        v0_q;
  assign prod_lo = time_i * cfg_i.sine_frequency;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (en_i) v0_q <= valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) phase_q <= prod_lo + {cfg_i.turn_offset, 16'd0};
  end

  // quadrant fold and angle
  logic [PHASE_BITS-1:0] idx;
  logic [UW-1:0]         u, ufold;
  logic [UW+32:0]        xprod;
  logic [30:0]           x1_q;
  logic [1:0]            quad1_q;
  logic                  v1_q;

  assign idx   = phase_q[31 -: PHASE_BITS];
  assign u     = UW'(idx[PHASE_BITS-3:0]);
  assign ufold = idx[PHASE_BITS-2] ? QSIZE - u : u;
  assign xprod = (UW+33)'(ufold) * (UW+33)'(TWO_PI_Q30);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en_i) v1_q <= v0_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q    <= xprod[PHASE_BITS +: 31];
      quad1_q <= idx[PHASE_BITS-1 -: 2];
    end
  end

  // x squared
  logic [61:0] xsq;
  sin_ctx_t    ctx_q [SIN_STEPS+1];
  logic [30:0] t_q   [SIN_STEPS+1];
  logic        v_q   [SIN_STEPS+1];

  assign xsq = 62'(x1_q) * 62'(x1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q[0] <= 1'b0;
    else if (en_i) v_q[0] <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx_q[0] <= '{x: x1_q, x2: xsq[61:30], quad: quad1_q};
      t_q[0]   <= Q30_ONE;
    end
  end

  // horner steps, three stages each
  for (genvar i = 0; i < SIN_STEPS; i++) begin : g_step
    localparam logic [7:0]  D     = 8'(SIN_DIV[i]);
    localparam logic [33:0] RECIP = 34'((64'd1 << 36) / 64'(SIN_DIV[i]));

    sin_ctx_t    ctx_a_q, ctx_b_q;
    logic [31:0] n_a_q, n_b_q, q0_b_q, r, d;
    logic        va_q, vb_q;
    logic [62:0] pa;
    logic [65:0] pb;

    assign pa = 63'(ctx_q[i].x2) * 63'(t_q[i]);
    assign pb = 66'(n_a_q) * 66'(RECIP);
    assign r  = n_b_q - q0_b_q * 32'(D);
    assign d  = q0_b_q + 32'(r >= 32'(D));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        va_q     <= 1'b0;
        vb_q     <= 1'b0;
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        va_q     <= v_q[i];
        vb_q     <= va_q;
        v_q[i+1] <= vb_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ctx_a_q    <= ctx_q[i];
        n_a_q      <= pa[61:30];
        ctx_b_q    <= ctx_a_q;
        n_b_q      <= n_a_q;
        q0_b_q     <= 32'(pb[65:36]);
        ctx_q[i+1] <= ctx_b_q;
        t_q[i+1]   <= (d >= 32'(Q30_ONE)) ? 31'd0 : Q30_ONE - 31'(d);
      end
    end
  end

  // sine value
  logic [61:0] sprod;
  logic [31:0] sraw;
  logic [30:0] s_q;
  logic [1:0]  quad_f_q;
  logic        vf_q;

  assign sprod = 62'(ctx_q[SIN_STEPS].x) * 62'(t_q[SIN_STEPS]);
  assign sraw  = sprod[61:30];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vf_q <= 1'b0;
    else if (en_i) vf_q <= v_q[SIN_STEPS];
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q      <= (sraw > 32'(Q30_ONE)) ? Q30_ONE : sraw[30:0];
      quad_f_q <= ctx_q[SIN_STEPS].quad;
    end
  end

  // amplitude scaling
  logic [15:0] amag;
  logic [46:0] mprod;
  logic        neg, vo_q;
  res_t        res_q;

  assign amag  = cfg_i.amplitude[15] ? 16'(-cfg_i.amplitude) : 16'(cfg_i.amplitude);
  assign mprod = 47'(amag) * 47'(s_q);
  assign neg   = quad_f_q[1] ^ cfg_i.amplitude[15];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else if (en_i) vo_q <= vf_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q.level        <= sat_level(mprod[45:30], neg);
      res_q.period_fault <= 1'b0;
    end
  end

  assign valid_o = vo_q;
  assign res_o   = res_q;

endmodule

// File: hdl/pwg_wave.sv
// ----------------------------------------------------------------------------
// pwg_wave
// Square, triangle and sawtooth pipeline: modulo, scale, divide by period.
// ----------------------------------------------------------------------------
module pwg_wave (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [31:0]   time_i,
  input  pwg_pkg::cfg_t cfg_i,
  output logic          valid_o,
  output pwg_pkg::res_t res_o
);
  import pwg_pkg::*;

  localparam int unsigned MOD_STEPS = 33;
  localparam int unsigned DIV_STEPS = 16;

  logic [31:0] per;
  assign per = cfg_i.wave_period;

  // time sum and modulo, one bit a stage
  logic [31:0] rem_q [MOD_STEPS+1];
  logic [32:0] dvd_q [MOD_STEPS+1];
  logic        mv_q  [MOD_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mv_q[0] <= 1'b0;
    else if (en_i) mv_q[0] <= valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= '0;
      dvd_q[0] <= 33'(time_i) + 33'(cfg_i.time_offset);
    end
  end

  for (genvar j = 0; j < MOD_STEPS; j++) begin : g_mod
    logic [32:0] trial;
    logic        ge;
    assign trial = {rem_q[j], dvd_q[j][32]};
    assign ge    = trial >= {1'b0, per};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) mv_q[j+1] <= 1'b0;
      else if (en_i) mv_q[j+1] <= mv_q[j];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1] <= ge ? 32'(trial - {1'b0, per}) : trial[31:0];
        dvd_q[j+1] <= {dvd_q[j][31:0], 1'b0};
      end
    end
  end

  // shape term
  logic [32:0]        r2;
  logic [33:0]        r4, p3;
  logic signed [35:0] m;
  logic [31:0]        mabs_q;
  logic               mneg_q, sqpos1_q, v1_q;

  assign r2 = {rem_q[MOD_STEPS], 1'b0};
  assign r4 = {rem_q[MOD_STEPS], 2'b00};
  assign p3 = 34'(per) + {1'b0, per, 1'b0};

  always_comb begin
    case (cfg_i.mode)
      MODE_TRIANGLE: begin
        if (r2 < {1'b0, per}) m = $signed(36'(r4)) - $signed(36'(per));
        else                  m = $signed(36'(p3)) - $signed(36'(r4));
      end
      default: m = $signed(36'(r2)) - $signed(36'(per));
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en_i) v1_q <= mv_q[MOD_STEPS];
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mabs_q   <= m[35] ? 32'(-m) : 32'(m);
      mneg_q   <= m[35];
      sqpos1_q <= r2 > {1'b0, per};
    end
  end

  // scale by amplitude
  logic [15:0] amag;
  logic [47:0] num_q;
  logic        neg2_q, sqpos2_q, v2_q;

  assign amag = cfg_i.amplitude[15] ? 16'(-cfg_i.amplitude) : 16'(cfg_i.amplitude);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en_i) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q    <= 48'(amag) * 48'(mabs_q);
      neg2_q   <= mneg_q ^ cfg_i.amplitude[15];
      sqpos2_q <= sqpos1_q;
    end
  end

  // divide by period, one quotient bit a stage
  logic [31:0] drem_q [DIV_STEPS+1];
  logic [15:0] dq_q   [DIV_STEPS+1];
  logic        dneg_q [DIV_STEPS+1];
  logic        dsq_q  [DIV_STEPS+1];
  logic        dv_q   [DIV_STEPS+1];

  assign drem_q[0] = num_q[47:16];
  assign dq_q[0]   = num_q[15:0];
  assign dneg_q[0] = neg2_q;
  assign dsq_q[0]  = sqpos2_q;
  assign dv_q[0]   = v2_q;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [32:0] trial;
    logic        ge;
    assign trial = {drem_q[k], dq_q[k][15]};
    assign ge    = trial >= {1'b0, per};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[k+1] <= 1'b0;
      else if (en_i) dv_q[k+1] <= dv_q[k];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        drem_q[k+1] <= ge ? 32'(trial - {1'b0, per}) : trial[31:0];
        dq_q[k+1]   <= {dq_q[k][14:0], ge};
        dneg_q[k+1] <= dneg_q[k];
        dsq_q[k+1]  <= dsq_q[k];
      end
    end
  end

  // final level
  logic signed [16:0] sa, sq_lvl;
  logic signed [15:0] level;
  logic               vo_q;
  res_t               res_q;

  assign sa     = {cfg_i.amplitude[15], cfg_i.amplitude};
  assign sq_lvl = dsq_q[DIV_STEPS] ? sa : -sa;

  always_comb begin
    if (per == '0) begin
      level = '0;
    end else if (cfg_i.mode == MODE_SQUARE) begin
      level = sat_level(sq_lvl[16] ? 16'(-sq_lvl) : 16'(sq_lvl), sq_lvl[16]);
    end else begin
      level = sat_level(dq_q[DIV_STEPS], dneg_q[DIV_STEPS]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else if (en_i) vo_q <= dv_q[DIV_STEPS];
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q.level        <= level;
      res_q.period_fault <= (per == '0);
    end
  end

  assign valid_o = vo_q;
  assign res_o   = res_q;

endmodule

// File: hdl/periodic_waveform_generator_unit.sv
// ----------------------------------------------------------------------------
// periodic_waveform_generator_unit
// Sine, square, triangle and sawtooth generator evaluated at Q16.16 times.
// ----------------------------------------------------------------------------
// One sample beat is taken every cycle while the output is not stalled,
// and one level beat is returned for each, in order. A sample passes the
// input register and a two-entry queue, then runs through the sine pipeline
// (23 stages, six polynomial steps of three stages) or the wave pipeline
// (53 stages, set by the 33-bit modulo and the 16-bit division by the
// period, one bit a stage), then the output register. The user must write
// registers only while no beat is in flight; the block does not enforce it.
module periodic_waveform_generator_unit #(
  parameter int unsigned SINE_PHASE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] sample_time
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] level
  output logic        m_axis_tuser    // [0] period_fault
);
  import pwg_pkg::*;

  cfg_t  cfg_q;
  logic  fr_valid, q_ready, q_valid, en, pop;
  item_t fr_item, q_item;
  logic  sine_v, wave_v, out_v_q;
  res_t  sine_res, wave_res, out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode           <= MODE_SINE;
      cfg_q.sine_frequency <= '0;
      cfg_q.wave_period    <= 32'd65536;
      cfg_q.amplitude      <= '0;
      cfg_q.time_offset    <= '0;
      cfg_q.turn_offset    <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_MODE:        cfg_q.mode           <= mode_e'(cfg_data_i[1:0]);
        REG_SINE_FREQ:   cfg_q.sine_frequency <= cfg_data_i;
        REG_WAVE_PERIOD: cfg_q.wave_period    <= cfg_data_i;
        REG_AMPLITUDE:   cfg_q.amplitude      <= $signed(cfg_data_i[15:0]);
        REG_TIME_OFFSET: cfg_q.time_offset    <= cfg_data_i;
        REG_TURN_OFFSET: cfg_q.turn_offset    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  pwg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_time_i   (s_axis_tdata),
    .mode_i      (cfg_q.mode),
    .out_valid_o (fr_valid),
    .out_ready_i (q_ready),
    .out_item_o  (fr_item)
  );

  pwg_queue #(.DEPTH(2)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (q_ready),
    .push_item_i  (fr_item),
    .pop_valid_o  (q_valid),
    .pop_i        (en),
    .pop_item_o   (q_item)
  );

  assign en  = !out_v_q || m_axis_tready;
  assign pop = en && q_valid;

  pwg_sine #(.PHASE_BITS(SINE_PHASE_BITS)) u_sine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pop && q_item.is_sine),
    .time_i  (q_item.sample_time),
    .cfg_i   (cfg_q),
    .valid_o (sine_v),
    .res_o   (sine_res)
  );

  pwg_wave u_wave (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pop && !q_item.is_sine),
    .time_i  (q_item.sample_time),
    .cfg_i   (cfg_q),
    .valid_o (wave_v),
    .res_o   (wave_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= sine_v || wave_v;
  end
  always_ff @(posedge clk_i) begin
    if (en) out_q <= sine_v ? sine_res : wave_res;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q.level;
  assign m_axis_tuser  = out_q.period_fault;

  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sine_v && wave_v))
    else $error("both units deliver a beat in the same cycle");

  a_fault_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (cfg_q.mode != MODE_SINE))
    else $error("period fault on a sine beat");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata != 16'h8000))
    else $error("level outside the clamped range");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 16'd0))
    else $error("faulted beat with a non-zero level");

endmodule

// File: verif/pwg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwg_checker
// Watches the register port and both streams of the waveform generator,
// keeps its own copy of the registers, works out the level and fault of each
// accepted sample beat and compares them, in order, with the level beats.
// ----------------------------------------------------------------------------
module pwg_checker #(
  parameter int unsigned SINE_PHASE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [31:0] s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [15:0] m_tdata_i,
  input  logic        m_tuser_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          level_beats_o,
  output int          fault_beats_o
);
  import pwg_pkg::*;

  typedef struct {
    logic signed [15:0] level;
    logic               fault;
  } level_exp_t;

  mode_e              wave_mode;
  logic [31:0]        sine_freq;
  logic [31:0]        wave_period;
  logic signed [15:0] amplitude;
  logic [31:0]        time_offset;
  logic [15:0]        turn_offset;
  level_exp_t         expected_levels[$];

  assign pending_o = expected_levels.size();

  function automatic logic signed [15:0] clamp_level(input longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32767) return -16'sd32767;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] sine_level_of(input logic [31:0] t);
    longint unsigned divs[6] = '{156, 110, 72, 42, 20, 6};
    longint unsigned prod, x, x2, poly, d, s, mag, amag;
    logic [31:0]     phase, idx, qsize, u;
    logic [1:0]      quad;
    logic            neg;
    prod  = longint'(t) * longint'(sine_freq);
    phase = prod[31:0] + {turn_offset, 16'h0000};
    idx   = phase >> (32 - SINE_PHASE_BITS);
    qsize = 32'd1 << (SINE_PHASE_BITS - 2);
    quad  = 2'((idx >> (SINE_PHASE_BITS - 2)) & 3);
    u     = idx & (qsize - 1);
    if (quad[0]) u = qsize - u;
    x  = (longint'(u) * 64'd6746518852) >> SINE_PHASE_BITS;
    x2 = (x * x) >> 30;
    poly = 64'd1 << 30;
    for (int i = 0; i < 6; i++) begin
      d    = ((x2 * poly) >> 30) / divs[i];
      poly = (d >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - d;
    end
    s = (x * poly) >> 30;
    if (s > (64'd1 << 30)) s = 64'd1 << 30;
    amag = (amplitude < 0) ? longint'(-longint'(amplitude)) : longint'(amplitude);
    mag  = (amag * s) >> 30;
    neg  = quad[1] ^ (amplitude < 0);
    return clamp_level(neg ? -longint'(mag) : longint'(mag));
  endfunction

  function automatic logic signed [15:0] wave_level_of(input logic [31:0] t);
    longint r, p, a, v;
    p = longint'(wave_period);
    a = longint'(amplitude);
    r = (longint'(t) + longint'(time_offset)) % p;
    case (wave_mode)
      MODE_SQUARE:   v = (2 * r > p) ? a : -a;
      MODE_TRIANGLE: v = (2 * r < p) ? (a * (4 * r - p)) / p : (a * (3 * p - 4 * r)) / p;
      default:       v = (a * (2 * r - p)) / p;
    endcase
    return clamp_level(v);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    level_exp_t e, got;
    int         n_fail;
    n_fail = 0;
    if (!rst_ni) begin
      wave_mode     <= MODE_SINE;
      sine_freq     <= '0;
      wave_period   <= 32'd65536;
      amplitude     <= '0;
      time_offset   <= '0;
      turn_offset   <= '0;
      fail_count_o  <= 0;
      level_beats_o <= 0;
      fault_beats_o <= 0;
      expected_levels.delete();
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        if (wave_mode == MODE_SINE) begin
          e.level = sine_level_of(s_tdata_i);
          e.fault = 1'b0;
        end else if (wave_period == 0) begin
          e.level = '0;
          e.fault = 1'b1;
        end else begin
          e.level = wave_level_of(s_tdata_i);
          e.fault = 1'b0;
        end
        expected_levels.push_back(e);
      end
      if (m_tvalid_i && m_tready_i) begin
        got.level = m_tdata_i;
        got.fault = m_tuser_i;
        level_beats_o <= level_beats_o + 1;
        if (got.fault) fault_beats_o <= fault_beats_o + 1;
        if (expected_levels.size() == 0) begin
          $error("level beat with nothing expected: level %0d fault %0b",
                 got.level, got.fault);
          n_fail++;
        end else begin
          e = expected_levels.pop_front();
          if (got.level !== e.level) begin
            $error("level: expected %0d, actual %0d", e.level, got.level);
            n_fail++;
          end
          if (got.fault !== e.fault) begin
            $error("period_fault: expected %0b, actual %0b", e.fault, got.fault);
            n_fail++;
          end
        end
      end
      if (n_fail != 0) fail_count_o <= fail_count_o + n_fail;
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_MODE:        wave_mode   <= mode_e'(cfg_data_i[1:0]);
          REG_SINE_FREQ:   sine_freq   <= cfg_data_i;
          REG_WAVE_PERIOD: wave_period <= cfg_data_i;
          REG_AMPLITUDE:   amplitude   <= cfg_data_i[15:0];
          REG_TIME_OFFSET: time_offset <= cfg_data_i;
          REG_TURN_OFFSET: turn_offset <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: verif/tb_periodic_waveform_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_waveform_generator_unit
// Drives sample times through all four waveforms under many register
// settings, with random gaps on both streams; a checker beside the block
// predicts every level beat and counts mismatches.
// ----------------------------------------------------------------------------
module tb_periodic_waveform_generator_unit;
  import pwg_pkg::*;

  localparam int DRAIN_CYCLES = 70;
  localparam int STALL_LIMIT  = 5000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;

  int fail_count, pending, level_beats, fault_beats;
  int tx_idle_pct, rx_idle_pct, stall_cycles, sample_count;

  periodic_waveform_generator_unit DUT (.*);

  pwg_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready), .s_tdata_i(s_axis_tdata),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready),
    .m_tdata_i(m_axis_tdata), .m_tuser_i(m_axis_tuser),
    .fail_count_o(fail_count), .pending_o(pending),
    .level_beats_o(level_beats), .fault_beats_o(fault_beats)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(negedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic send_sample(input logic [31:0] t);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = t;
    do @(posedge clk_i); while (!s_axis_tready);
    sample_count++;
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(5))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(1, 32'h0004_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_amplitude();
    case ($urandom_range(5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h8001;
      3:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    mode_e m;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; m_axis_tready = 1'b0;
    tx_idle_pct = 0; rx_idle_pct = 0; stall_cycles = 0; sample_count = 0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset settings, then edges of every waveform
    send_sample(32'h0);
    send_sample(32'hFFFF_FFFF);
    wait_drained();
    write_reg(REG_AMPLITUDE, 32'h7FFF);
    write_reg(REG_SINE_FREQ, 32'h0001_0000);
    write_reg(REG_TURN_OFFSET, 32'h0);
    for (int q = 0; q < 5; q++) send_sample(q * 32'h4000);
    send_sample(32'hFFFF_FFFF);
    wait_drained();
    write_reg(REG_AMPLITUDE, 32'h8000);
    write_reg(REG_SINE_FREQ, 32'hFFFF_FFFF);
    write_reg(REG_TURN_OFFSET, 32'hFFFF);
    send_sample(32'h0);
    send_sample(32'h1234_5678);
    wait_drained();
    write_reg(REG_MODE, 32'(MODE_SQUARE));
    write_reg(REG_WAVE_PERIOD, 32'h0);
    send_sample(32'h0);
    send_sample(32'hFFFF_FFFF);
    wait_drained();
    write_reg(REG_WAVE_PERIOD, 32'h0001_0000);
    write_reg(REG_TIME_OFFSET, 32'hFFFF_FFFF);
    send_sample(32'h0);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_8001);
    wait_drained();
    write_reg(REG_MODE, 32'(MODE_TRIANGLE));
    write_reg(REG_TIME_OFFSET, 32'h0);
    write_reg(REG_AMPLITUDE, 32'h7FFF);
    for (int q = 0; q < 4; q++) send_sample(q * 32'h4000);
    wait_drained();
    write_reg(REG_MODE, 32'(MODE_SAWTOOTH));
    write_reg(REG_WAVE_PERIOD, 32'hFFFF_FFFF);
    send_sample(32'h0);
    send_sample(32'hFFFF_FFFE);
    send_sample(32'h7FFF_FFFF);
    wait_drained();

    // random: a fresh register setting per phase, idling changes with progress
    for (int ph = 0; ph < 15; ph++) begin
      m = mode_e'(ph % 4);
      if (ph < 5)       begin tx_idle_pct = 33; rx_idle_pct = 57; end
      else if (ph < 10) begin tx_idle_pct = 57; rx_idle_pct = 33; end
      else              begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      write_reg(REG_MODE, 32'(m));
      write_reg(REG_SINE_FREQ, pick_word());
      write_reg(REG_WAVE_PERIOD, ($urandom_range(9) == 0) ? 32'h0 : pick_word());
      write_reg(REG_AMPLITUDE, 32'(pick_amplitude()));
      write_reg(REG_TIME_OFFSET, pick_word());
      write_reg(REG_TURN_OFFSET, $urandom_range(16'hFFFF));
      for (int i = 0; i < 50; i++) send_sample($urandom);
      wait_drained();
    end

    $display("%0d samples over all four waveforms, %0d level beats checked, %0d faults",
             sample_count, level_beats, fault_beats);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
